// ===== rtl/core/lslf_pkg.sv =====
// lslf_pkg: shared constants and types for the least-squares line fit core
// no dependencies

package lslf_pkg;

    localparam int MAX_POINTS_DEF    = 65536;
    localparam int IN_FRAC_BITS_DEF  = 8;
    localparam int OUT_FRAC_BITS_DEF = 16;

    localparam int CNT_W  = 17;
    localparam int SUM_W  = 33;
    localparam int SQ_W   = 48;
    localparam int WIDE_W = 128;
    localparam int DEN_W  = 64;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_DEGEN = 2'd1;
    localparam logic [1:0] STATUS_SAT   = 2'd2;

    // product selector for the shared multiplier
    typedef enum logic [2:0] {
        MUL_N_SXX,
        MUL_SX_SX,
        MUL_N_SXY,
        MUL_SX_SY,
        MUL_SXX_SY,
        MUL_SX_SXY
    } mul_sel_t;

    // commands from controller to datapath
    typedef struct packed {
        logic     acc;        // accumulate the input point
        logic     mul_go;     // start a product
        mul_sel_t mul_sel;
        logic     load_den;   // product -> den (first) / subtract (second)
        logic     sub_den;
        logic     load_num;
        logic     sub_num;
        logic     div_go;     // start division of num by den
        logic     div_a;      // intercept division (different scale)
        logic     emit;
        logic     clear;
    } lslf_cmd_t;

    // status back to controller
    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic den_zero;
    } lslf_stat_t;

endpackage

// ===== rtl/core/least_squares_line_fit_core.sv =====
// least_squares_line_fit_core: top level of the streaming line fit
// depends on lslf_pkg, lslf_ctrl, lslf_datapath
//
// Usage:
//   Drive x, y (signed Q8.8) and last with start; a request is taken at a
//   rising edge where start is high and busy is low.
//   Points without last are absorbed at one point per clock.
//   A request with last closes the set: the core computes the denominator
//   and both numerators on one shared multiplier (6 products) and runs two
//   restoring divisions, with busy high until the result is out; a zero
//   denominator finishes early, after the two denominator products.
//   The result (intercept, slope, status, points) is shown for exactly one
//   cycle with done high, the last busy cycle; the receiver cannot stall,
//   it must take it then.
//   After the result all sums are cleared and a new set may begin.
//   Points beyond MAX_POINTS in one set are dropped; last still closes the set.
//   rst_n is asynchronous active low and clears all sums and control.

module least_squares_line_fit_core #(
    parameter int MAX_POINTS    = lslf_pkg::MAX_POINTS_DEF,
    parameter int IN_FRAC_BITS  = lslf_pkg::IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = lslf_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [15:0]         x,
    input  logic signed [15:0]         y,
    input  logic                       last,
    output logic                       done,
    output logic signed [31:0]         intercept,
    output logic signed [31:0]         slope,
    output logic [1:0]                 status,
    output logic [lslf_pkg::CNT_W-1:0] points
);
    import lslf_pkg::*;

    lslf_cmd_t  cmd;
    lslf_stat_t stat;
    logic       busy_int;

    lslf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (last),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy_int)
    );

    lslf_datapath #(
        .MAX_POINTS    (MAX_POINTS),
        .IN_FRAC_BITS  (IN_FRAC_BITS),
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .x         (x),
        .y         (y),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .intercept (intercept),
        .slope     (slope),
        .status    (status),
        .points    (points)
    );

    assign busy = busy_int;

endmodule

// ===== rtl/core/lslf_datapath.sv =====
// lslf_datapath: sums, shared sequential multiplier, restoring divider, output regs
// depends on lslf_pkg

module lslf_datapath #(
    parameter int MAX_POINTS    = lslf_pkg::MAX_POINTS_DEF,
    parameter int IN_FRAC_BITS  = lslf_pkg::IN_FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = lslf_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic signed [15:0]       x,
    input  logic signed [15:0]       y,
    input  lslf_pkg::lslf_cmd_t      cmd,
    output lslf_pkg::lslf_stat_t     stat,
    output logic                     done,
    output logic signed [31:0]       intercept,
    output logic signed [31:0]       slope,
    output logic [1:0]               status,
    output logic [lslf_pkg::CNT_W-1:0] points
);
    import lslf_pkg::*;

    localparam int SHIFT_B = OUT_FRAC_BITS + 1;
    localparam int SA      = OUT_FRAC_BITS - IN_FRAC_BITS;
    localparam int SHIFT_A = (SA >= 0) ? SA + 1 : 1;
    localparam int RSH_A   = (SA < 0) ? -SA : 0;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

    // accumulators
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [SUM_W-1:0] sx_reg, sy_reg;
    logic signed [SQ_W-1:0]  sxx_reg, sxy_reg;
    logic signed [31:0]      xx, xy;

    assign xx = x * x;
    assign xy = x * y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            sxy_reg <= '0;
        end
        else if (cmd.clear)
        begin
            cnt_reg <= '0;
            sx_reg  <= '0;
            sy_reg  <= '0;
            sxx_reg <= '0;
            sxy_reg <= '0;
        end
        else if (cmd.acc && cnt_reg < MAX_CNT)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            sx_reg  <= sx_reg + SUM_W'(x);
            sy_reg  <= sy_reg + SUM_W'(y);
            sxx_reg <= sxx_reg + SQ_W'(xx);
            sxy_reg <= sxy_reg + SQ_W'(xy);
        end
    end

    // shared multiplier: magnitudes, 16 bits of b per cycle
    logic signed [SQ_W:0] opa, opb;
    logic [SQ_W-1:0]      ma_reg, mb_reg;
    logic                 mneg_reg;
    logic [WIDE_W-1:0]    prod_reg;
    logic [1:0]           mstep_reg;
    logic                 mbusy_reg, mdone_reg;
    logic [SQ_W+15:0]     pp;

    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_N_SXX:  begin opa = (SQ_W+1)'(signed'({1'b0, cnt_reg})); opb = (SQ_W+1)'(sxx_reg); end
            MUL_SX_SX:  begin opa = (SQ_W+1)'(sx_reg);  opb = (SQ_W+1)'(sx_reg);  end
            MUL_N_SXY:  begin opa = (SQ_W+1)'(signed'({1'b0, cnt_reg})); opb = (SQ_W+1)'(sxy_reg); end
            MUL_SX_SY:  begin opa = (SQ_W+1)'(sx_reg);  opb = (SQ_W+1)'(sy_reg);  end
            MUL_SXX_SY: begin opa = (SQ_W+1)'(sxx_reg); opb = (SQ_W+1)'(sy_reg);  end
            MUL_SX_SXY: begin opa = (SQ_W+1)'(sx_reg);  opb = (SQ_W+1)'(sxy_reg); end
            default:    begin opa = '0; opb = '0; end
        endcase
    end

    assign pp = ma_reg * mb_reg[15:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            mdone_reg <= 1'b0;
            mstep_reg <= '0;
        end
        else
        begin
            mdone_reg <= 1'b0;
            if (cmd.mul_go)
            begin
                mbusy_reg <= 1'b1;
                mstep_reg <= '0;
                ma_reg    <= opa[SQ_W] ? SQ_W'(-opa) : SQ_W'(opa);
                mb_reg    <= opb[SQ_W] ? SQ_W'(-opb) : SQ_W'(opb);
                mneg_reg  <= opa[SQ_W] ^ opb[SQ_W];
                prod_reg  <= '0;
            end
            else if (mbusy_reg)
            begin
                prod_reg  <= prod_reg + (WIDE_W'(pp) << (16 * mstep_reg));
                mb_reg    <= mb_reg >> 16;
                mstep_reg <= mstep_reg + 1'b1;
                if (mstep_reg == 2'd2)
                begin
                    mbusy_reg <= 1'b0;
                    mdone_reg <= 1'b1;
                end
            end
        end
    end

    logic [WIDE_W-1:0] sprod;
    assign sprod = mneg_reg ? (~prod_reg + 1'b1) : prod_reg;

    // denominator and numerator registers
    logic [WIDE_W-1:0] den_reg, num_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.load_den) den_reg <= sprod;
        if (cmd.sub_den)  den_reg <= den_reg - sprod;
        if (cmd.load_num) num_reg <= sprod;
        if (cmd.sub_num)  num_reg <= num_reg - sprod;
    end
    assign stat.den_zero = (den_reg == '0);
    assign stat.mul_done = mdone_reg;

    // restoring divider, one quotient bit per cycle over 128 dividend bits
    logic [WIDE_W-1:0] dvd_reg;
    logic [DEN_W:0]    rem_reg;
    logic [50:0]       q_reg;
    logic              big_reg, dneg_reg, dbusy_reg, ddone_reg, da_reg;
    logic [6:0]        dcnt_reg;
    logic [WIDE_W-1:0] nmag;
    logic [DEN_W:0]    rsh, rsub;

    assign nmag = num_reg[WIDE_W-1] ? (~num_reg + 1'b1) : num_reg;
    assign rsh  = {rem_reg[DEN_W-1:0], dvd_reg[WIDE_W-1]};
    assign rsub = rsh - {1'b0, den_reg[DEN_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0;
            ddone_reg <= 1'b0;
            dcnt_reg  <= '0;
        end
        else
        begin
            ddone_reg <= 1'b0;
            if (cmd.div_go)
            begin
                dbusy_reg <= 1'b1;
                dcnt_reg  <= '0;
                dvd_reg   <= cmd.div_a ? (nmag << SHIFT_A) : (nmag << SHIFT_B);
                dneg_reg  <= num_reg[WIDE_W-1];
                da_reg    <= cmd.div_a;
                rem_reg   <= '0;
                q_reg     <= '0;
                big_reg   <= 1'b0;
            end
            else if (dbusy_reg)
            begin
                dvd_reg  <= dvd_reg << 1;
                rem_reg  <= rsub[DEN_W] ? rsh : rsub;
                if (q_reg[50])
                    big_reg <= 1'b1;
                else
                    q_reg <= {q_reg[49:0], ~rsub[DEN_W]};
                dcnt_reg <= dcnt_reg + 1'b1;
                if (dcnt_reg == 7'd127)
                begin
                    dbusy_reg <= 1'b0;
                    ddone_reg <= 1'b1;
                end
            end
        end
    end
    assign stat.div_done = ddone_reg;

    // round, clamp and capture each quotient
    logic [50:0] qs, qr;
    logic [31:0] lim;
    logic        qsat;
    logic signed [31:0] qval;

    always_comb
    begin
        qs   = da_reg ? (q_reg >> RSH_A) : q_reg;
        // one extra bit so the rounding add cannot wrap
        qr   = 51'(({1'b0, qs} + 52'd1) >> 1);
        lim  = dneg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        qsat = big_reg || (qr > 51'(lim));
        qval = qsat ? lim : qr[31:0];
        if (dneg_reg)
            qval = -qval;
    end

    logic signed [31:0] a_reg, b_reg;
    logic               sat_reg;
    logic [1:0]         status_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   pts_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            sat_reg    <= 1'b0;
            a_reg      <= '0;
            b_reg      <= '0;
            pts_reg    <= '0;
            status_reg <= STATUS_OK;
            intercept  <= '0;
            slope      <= '0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.clear)
                sat_reg <= 1'b0;
            if (ddone_reg)
            begin
                if (da_reg) a_reg <= qval;
                else        b_reg <= qval;
                if (qsat) sat_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                pts_reg <= cnt_reg;
                if (stat.den_zero)
                begin
                    status_reg <= STATUS_DEGEN;
                    intercept  <= '0;
                    slope      <= '0;
                end
                else
                begin
                    status_reg <= sat_reg ? STATUS_SAT : STATUS_OK;
                    intercept  <= a_reg;
                    slope      <= b_reg;
                end
            end
        end
    end

    assign done   = done_reg;
    assign status = status_reg;
    assign points = pts_reg;

endmodule

// ===== rtl/core/lslf_ctrl.sv =====
// lslf_ctrl: sequencer for accumulation and the fit at the end of a set
// depends on lslf_pkg

module lslf_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  last,
    input  lslf_pkg::lslf_stat_t  stat,
    output lslf_pkg::lslf_cmd_t   cmd,
    output logic                  busy
);
    import lslf_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_M1    = 4'd1;
    localparam logic [3:0] S_M2    = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_M3    = 4'd4;
    localparam logic [3:0] S_M4    = 4'd5;
    localparam logic [3:0] S_DB    = 4'd6;
    localparam logic [3:0] S_M5    = 4'd7;
    localparam logic [3:0] S_M6    = 4'd8;
    localparam logic [3:0] S_DA    = 4'd9;
    localparam logic [3:0] S_EMIT  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       wait_reg, wait_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wait_reg  <= wait_next;
        end
    end

    // each multiply state issues the product once, then waits for it
    always_comb
    begin
        cmd        = '0;
        cmd.mul_sel = MUL_N_SXX;
        state_next = state_reg;
        wait_next  = wait_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                // no request is taken during the clearing cycle
                if (start && !wait_reg)
                begin
                    cmd.acc = 1'b1;
                    if (last)
                    begin
                        state_next = S_M1;
                        wait_next  = 1'b0;
                    end
                end
            end
            S_M1, S_M2, S_M3, S_M4, S_M5, S_M6:
            begin
                unique case (state_reg)
                    S_M1:    cmd.mul_sel = MUL_N_SXX;
                    S_M2:    cmd.mul_sel = MUL_SX_SX;
                    S_M3:    cmd.mul_sel = MUL_N_SXY;
                    S_M4:    cmd.mul_sel = MUL_SX_SY;
                    S_M5:    cmd.mul_sel = MUL_SXX_SY;
                    default: cmd.mul_sel = MUL_SX_SXY;
                endcase
                if (!wait_reg)
                begin
                    cmd.mul_go = 1'b1;
                    wait_next  = 1'b1;
                end
                else if (stat.mul_done)
                begin
                    wait_next = 1'b0;
                    unique case (state_reg)
                        S_M1:    begin cmd.load_den = 1'b1; state_next = S_M2;  end
                        S_M2:    begin cmd.sub_den  = 1'b1; state_next = S_CHK; end
                        S_M3:    begin cmd.load_num = 1'b1; state_next = S_M4;  end
                        S_M4:    begin cmd.sub_num  = 1'b1; state_next = S_DB;  end
                        S_M5:    begin cmd.load_num = 1'b1; state_next = S_M6;  end
                        default: begin cmd.sub_num  = 1'b1; state_next = S_DA;  end
                    endcase
                end
            end
            S_CHK:
                state_next = stat.den_zero ? S_EMIT : S_M3;
            S_DB, S_DA:
            begin
                cmd.div_a = (state_reg == S_DA);
                if (!wait_reg)
                begin
                    cmd.div_go = 1'b1;
                    wait_next  = 1'b1;
                end
                else if (stat.div_done)
                begin
                    wait_next  = 1'b0;
                    state_next = (state_reg == S_DB) ? S_M5 : S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        // sums clear the cycle after the result is captured
        cmd.clear = (state_reg == S_IDLE) && wait_reg;
        if (state_reg == S_EMIT)
            wait_next = 1'b1;
        else if (state_reg == S_IDLE)
            wait_next = 1'b0;
    end

    assign busy = (state_reg != S_IDLE) || wait_reg;

endmodule
